/* design/tmmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmmc_pkg: shared types and constants of the timed motor move controller
// Item and result structs, phase and sequencer codes, register indexes,
// control structs of the serial arithmetic unit and small helper functions.
// ----------------------------------------------------------------------------
package tmmc_pkg;

    // Serial arithmetic unit widths
    localparam int AW    = 42;          // work register: dividend / product
    localparam int BW    = 16;          // multiplier / divisor
    localparam int MW    = AW - BW;     // multiplicand width
    localparam int CNT_W = 6;           // step counter, holds AW

    // Move arithmetic widths
    localparam int TRAV_W      = 27;    // travel in Q.8 mm after compensation
    localparam int NUM_W       = 28;    // run time dividend incl. rounding term
    localparam int RT_MAX_BITS = 48;    // widest supported run time counter

    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [6:0]  RAMP_STEPS  = 7'd73;
    localparam logic [10:0] RAMP_FIRST  = 11'd300;
    localparam logic [10:0] FULL_DUTY   = 11'd1024;
    localparam logic [BW-1:0] WEIGHT_DIV = 16'd32855;
    localparam logic [BW-1:0] SPAN_DIV   = 16'd100;

    typedef struct packed {
        logic       action;
        logic [6:0] target_position;
    } item_t;

    typedef struct packed {
        logic [10:0] drive_duty;
        logic        backward;
        logic [6:0]  position;
        logic        busy_res;
        logic        move_accepted;
    } result_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RAMP,
        PH_RUN
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAN,
        S_TRAV,
        S_CHECK,
        S_WMUL,
        S_WDIV,
        S_RTPREP,
        S_RTDIV,
        S_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        REG_SS_STEP,
        REG_SS_LEN,
        REG_FULL_LEN,
        REG_STEP,
        REG_WEIGHT,
        REG_WOB,
        REG_START_POS
    } cfg_reg_t;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [CNT_W-1:0] cnt;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_sta_t;

    function automatic logic [6:0] clamp_pct(input logic [6:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    function automatic logic [10:0] duty_of(input phase_t ph, input logic [6:0] idx);
        logic [10:0] d;
        case (ph)
            PH_RAMP: d = RAMP_FIRST + (11'(idx) << 3) + (11'(idx) << 1);
            PH_RUN:  d = FULL_DUTY;
            default: d = 11'd0;
        endcase
        return d;
    endfunction

endpackage

/* design/tmmc_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmmc_alu: bit-serial multiply / divide unit
// Shift-add multiply, one multiplier bit per cycle, and restoring divide,
// one quotient bit per cycle. The result sits in the work register.
// ----------------------------------------------------------------------------
module tmmc_alu (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tmmc_pkg::alu_req_t     req,
    input  logic [tmmc_pkg::AW-1:0] a,
    input  logic [tmmc_pkg::BW-1:0] b,
    output tmmc_pkg::alu_sta_t     sta,
    output logic [tmmc_pkg::AW-1:0] res
);
    import tmmc_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    alu_op_t          op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    work_reg, work_next;
    logic [BW-1:0]    rem_reg, rem_next;
    logic [MW-1:0]    mcand_reg, mcand_next;
    logic [BW-1:0]    dvsr_reg, dvsr_next;

    logic [MW:0]      psum;
    logic [BW:0]      rsh;
    logic [BW:0]      rdiff;
    logic             ge;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        mcand_next = mcand_reg;
        dvsr_next  = dvsr_reg;

        psum  = {1'b0, work_reg[AW-1:BW]} + (work_reg[0] ? {1'b0, mcand_reg} : '0);
        rsh   = {rem_reg, work_reg[AW-1]};
        rdiff = rsh - {1'b0, dvsr_reg};
        ge    = (rsh >= {1'b0, dvsr_reg});

        if (req.start)
        begin
            busy_next  = 1'b1;
            op_next    = req.op;
            cnt_next   = req.cnt;
            rem_next   = '0;
            mcand_next = a[MW-1:0];
            dvsr_next  = b;
            case (req.op)
                OP_MUL:  work_next = {{MW{1'b0}}, b};
                OP_DIV:  work_next = a;
                default: work_next = a;
            endcase
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:  work_next = {psum, work_reg[BW-1:1]};
                OP_DIV:
                begin
                    // shift next dividend bit into the partial remainder
                    rem_next  = ge ? rdiff[BW-1:0] : rsh[BW-1:0];
                    work_next = {work_reg[AW-2:0], ge};
                end
                default: work_next = work_reg;
            endcase
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        mcand_reg <= mcand_next;
        dvsr_reg  <= dvsr_next;
    end

    assign sta.busy = busy_reg;
    assign sta.done = done_reg;
    assign res      = work_reg;

endmodule

/* design/timed_motor_move_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_motor_move_controller: open-loop timed move of a covering motor
// Takes 1 ms ticks and move requests, runs a soft-start duty ramp unless hold is
// 0, then a timed full-duty run; reports duty, direction and position per item.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one beat per tick (action 0) or move request (action 1).
//   result channel : exactly one beat per item: duty, direction, position,
//                    busy flag and whether a move started.
//   cfg channel    : cfg_index selects the register, cfg_data carries the
//                    value; always ready. Write only while the block is idle.
//                    Writing start_position reloads the position at once.
// Timing:
//   A tick, or a move that arrives while a motion is running, produces its
//   result on the next cycle, so ticks sustain one beat per cycle while
//   the receiver keeps up. An accepted move goes through the bit-serial
//   multiply/divide unit, plus a weight pass for backward compensation;
//   the 42-step divide by 32855 and the 28-step run time divide dominate.
//   Only one item is in work at a time; item_ready is low while a move is
//   computed and while the result register holds a beat nobody has taken.
// Reset:
//   Clears the motion state (idle, forward, position 0) and loads the
//   register defaults: hold 10, step 1.0 mm/ms, everything else zero.
//   A stalled receiver simply holds the result register and blocks input.
// ----------------------------------------------------------------------------
module timed_motor_move_controller #(
    parameter int RUN_TIME_BITS = 36
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tmmc_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output tmmc_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [23:0]       cfg_data
);
    import tmmc_pkg::*;

    localparam logic [RT_MAX_BITS-1:0] RT_LIM =
        (RT_MAX_BITS'(1) << RUN_TIME_BITS) - RT_MAX_BITS'(1);

    // Configuration registers
    logic [7:0]  ss_step_reg;
    logic [23:0] ss_len_reg;
    logic [15:0] full_len_reg;
    logic [15:0] step_reg;
    logic [15:0] weight_reg;
    logic        wob_reg;

    // Motion state
    seq_state_t               seq_reg, seq_next;
    phase_t                   phase_reg, phase_next;
    logic [6:0]               pct_reg, pct_next;
    logic                     bwd_reg, bwd_next;
    logic [6:0]               idx_reg, idx_next;
    logic [7:0]               hold_reg, hold_next;
    logic [RUN_TIME_BITS-1:0] run_reg, run_next;

    // Move computation scratch
    logic [6:0]               tgt_reg, tgt_next;
    logic [6:0]               diff_reg, diff_next;
    logic                     mbwd_reg, mbwd_next;
    logic                     short_reg, short_next;
    logic [TRAV_W-1:0]        trav_reg, trav_next;
    logic [RUN_TIME_BITS-1:0] rt_reg, rt_next;

    // Result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    // Arithmetic unit hookup
    alu_req_t      alu_req;
    alu_sta_t      alu_sta;
    logic [AW-1:0] alu_a;
    logic [BW-1:0] alu_b;
    logic [AW-1:0] alu_res;

    logic                   out_free;
    logic                   accepted;
    logic                   out_load;
    logic [15:0]            step_eff;
    logic [6:0]             tgt_c;
    logic [7:0]             hold_inc;
    logic [6:0]             idx_inc;
    logic [24:0]            need;
    logic [NUM_W-1:0]       num;
    logic [RT_MAX_BITS-1:0] rt_ext;
    logic [RT_MAX_BITS-1:0] rt_sat;

    tmmc_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (alu_a),
        .b     (alu_b),
        .sta   (alu_sta),
        .res   (alu_res)
    );

    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        pct_next   = pct_reg;
        bwd_next   = bwd_reg;
        idx_next   = idx_reg;
        hold_next  = hold_reg;
        run_next   = run_reg;
        tgt_next   = tgt_reg;
        diff_next  = diff_reg;
        mbwd_next  = mbwd_reg;
        short_next = short_reg;
        trav_next  = trav_reg;
        rt_next    = rt_reg;
        accepted   = 1'b0;
        out_load   = 1'b0;
        alu_req    = '0;
        alu_a      = '0;
        alu_b      = '0;

        out_free   = !out_valid_reg || result_ready;
        item_ready = (seq_reg == S_IDLE) && out_free;
        step_eff   = (step_reg == 16'd0) ? 16'd1 : step_reg;
        tgt_c      = clamp_pct(item.target_position);
        hold_inc   = hold_reg + 8'd1;
        idx_inc    = idx_reg + 7'd1;
        need       = {1'b0, ss_len_reg} + {9'd0, step_eff};
        // rounding term turns the floor divide into a ceiling
        num        = {1'b0, trav_reg} - {4'd0, ss_len_reg}
                     + {12'd0, step_eff} - NUM_W'(1);
        rt_ext     = {{(RT_MAX_BITS-NUM_W){1'b0}}, alu_res[NUM_W-1:0]};
        rt_sat     = (rt_ext > RT_LIM) ? RT_LIM : rt_ext;

        case (seq_reg)
            S_IDLE:
            begin
                if (item_valid && item_ready)
                begin
                    if (item.action && phase_reg == PH_IDLE)
                    begin
                        // start a move: span = full length / 100
                        tgt_next  = tgt_c;
                        mbwd_next = (tgt_c < pct_reg);
                        diff_next = (tgt_c < pct_reg) ? pct_reg - tgt_c : tgt_c - pct_reg;
                        alu_req   = '{start: 1'b1, op: OP_DIV, cnt: CNT_W'(16)};
                        alu_a     = {full_len_reg, {(AW-16){1'b0}}};
                        alu_b     = SPAN_DIV;
                        seq_next  = S_SPAN;
                    end
                    else
                    begin
                        if (!item.action)
                        begin
                            case (phase_reg)
                                PH_RAMP:
                                begin
                                    if (hold_inc >= ss_step_reg)
                                    begin
                                        hold_next = 8'd0;
                                        if (idx_inc >= RAMP_STEPS)
                                        begin
                                            idx_next   = 7'd0;
                                            phase_next = PH_RUN;
                                        end
                                        else
                                        begin
                                            idx_next = idx_inc;
                                        end
                                    end
                                    else
                                    begin
                                        hold_next = hold_inc;
                                    end
                                end
                                PH_RUN:
                                begin
                                    if (run_reg <= RUN_TIME_BITS'(1))
                                    begin
                                        run_next   = '0;
                                        phase_next = PH_IDLE;
                                    end
                                    else
                                    begin
                                        run_next = run_reg - RUN_TIME_BITS'(1);
                                    end
                                end
                                default: phase_next = PH_IDLE;
                            endcase
                        end
                        out_load = 1'b1;
                    end
                end
            end
            S_SPAN:
            begin
                if (alu_sta.done)
                begin
                    alu_req  = '{start: 1'b1, op: OP_MUL, cnt: CNT_W'(BW)};
                    alu_a    = {{(AW-10){1'b0}}, alu_res[9:0]};
                    alu_b    = {9'd0, diff_reg};
                    seq_next = S_TRAV;
                end
            end
            S_TRAV:
            begin
                if (alu_sta.done)
                begin
                    trav_next = {2'd0, alu_res[16:0], 8'd0};
                    seq_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (trav_reg < {2'd0, need})
                begin
                    short_next = 1'b1;
                    seq_next   = S_DONE;
                end
                else if (mbwd_reg && wob_reg)
                begin
                    short_next = 1'b0;
                    alu_req    = '{start: 1'b1, op: OP_MUL, cnt: CNT_W'(BW)};
                    alu_a      = {{(AW-TRAV_W){1'b0}}, trav_reg};
                    alu_b      = weight_reg;
                    seq_next   = S_WMUL;
                end
                else
                begin
                    short_next = 1'b0;
                    seq_next   = S_RTPREP;
                end
            end
            S_WMUL:
            begin
                if (alu_sta.done)
                begin
                    alu_req  = '{start: 1'b1, op: OP_DIV, cnt: CNT_W'(AW)};
                    alu_a    = alu_res;
                    alu_b    = WEIGHT_DIV;
                    seq_next = S_WDIV;
                end
            end
            S_WDIV:
            begin
                if (alu_sta.done)
                begin
                    trav_next = trav_reg + alu_res[TRAV_W-1:0];
                    seq_next  = S_RTPREP;
                end
            end
            S_RTPREP:
            begin
                alu_req  = '{start: 1'b1, op: OP_DIV, cnt: CNT_W'(NUM_W)};
                alu_a    = {num, {(AW-NUM_W){1'b0}}};
                alu_b    = step_eff;
                seq_next = S_RTDIV;
            end
            S_RTDIV:
            begin
                if (alu_sta.done)
                begin
                    rt_next  = rt_sat[RUN_TIME_BITS-1:0];
                    seq_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    // commit: direction always, motion only for a long enough move
                    bwd_next = mbwd_reg;
                    if (!short_reg)
                    begin
                        accepted = 1'b1;
                        pct_next = tgt_reg;
                        run_next = rt_reg;
                        if (ss_step_reg != 8'd0)
                        begin
                            phase_next = PH_RAMP;
                            idx_next   = 7'd0;
                            hold_next  = 8'd0;
                        end
                        else
                        begin
                            phase_next = PH_RUN;
                        end
                    end
                    out_load = 1'b1;
                    seq_next = S_IDLE;
                end
            end
            default: seq_next = S_IDLE;
        endcase

        out_next.drive_duty    = duty_of(phase_next, idx_next);
        out_next.backward      = bwd_next;
        out_next.position      = pct_next;
        out_next.busy_res      = (phase_next != PH_IDLE);
        out_next.move_accepted = accepted;

        out_valid_next = out_valid_reg && !result_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        // a start position write reloads the position
        if (cfg_valid && cfg_index == REG_START_POS)
        begin
            pct_next = clamp_pct(cfg_data[6:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_IDLE;
            phase_reg     <= PH_IDLE;
            pct_reg       <= '0;
            bwd_reg       <= 1'b0;
            idx_reg       <= '0;
            hold_reg      <= '0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            pct_reg       <= pct_next;
            bwd_reg       <= bwd_next;
            idx_reg       <= idx_next;
            hold_reg      <= hold_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg   <= tgt_next;
        diff_reg  <= diff_next;
        mbwd_reg  <= mbwd_next;
        short_reg <= short_next;
        trav_reg  <= trav_next;
        rt_reg    <= rt_next;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // Register file: the start position itself only reloads the position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_step_reg  <= 8'd10;
            ss_len_reg   <= '0;
            full_len_reg <= '0;
            step_reg     <= 16'd256;
            weight_reg   <= '0;
            wob_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SS_STEP:  ss_step_reg  <= cfg_data[7:0];
                REG_SS_LEN:   ss_len_reg   <= cfg_data;
                REG_FULL_LEN: full_len_reg <= cfg_data[15:0];
                REG_STEP:     step_reg     <= cfg_data[15:0];
                REG_WEIGHT:   weight_reg   <= cfg_data[15:0];
                REG_WOB:      wob_reg      <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // The arithmetic unit is only started when it is free
    a_alu_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> !alu_sta.busy)
        else $error("arithmetic unit restarted while busy");

    // A finished operation is only reported to a state that waits for it
    a_alu_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
        alu_sta.done |-> (seq_reg == S_SPAN || seq_reg == S_TRAV ||
                          seq_reg == S_WMUL || seq_reg == S_WDIV ||
                          seq_reg == S_RTDIV))
        else $error("arithmetic result arrived in an unexpected state");

    // The timed run always has time left while it lasts
    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RUN |-> run_reg != '0)
        else $error("run phase with no remaining time");

    // The ramp index stays within the duty table
    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RAMP |-> idx_reg < RAMP_STEPS)
        else $error("ramp index out of range");

    // No new beat is taken while a move is being computed
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg != S_IDLE |-> !item_ready)
        else $error("item taken during move computation");

endmodule

/* sim/tb_timed_motor_move_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_motor_move_controller: self-checking bench of the timed move block
// Walks a short table of directed beats (reset state, field extremes, refused and short
// moves, saturation, zero step, spare register index), then several random register
// settings with mostly well-formed move/tick sequences. Every result beat is compared
// field by field against fixed values on some table rows, else against an in-bench model
// of the ramp, run and position logic. Both handshakes see random idle bursts.
// ----------------------------------------------------------------------------
module tb_timed_motor_move_controller;

    import tmmc_pkg::*;

    // Model constants of the drive profile
    localparam int unsigned RUN_BITS   = 36;
    localparam logic [63:0] RUN_CAP    = (64'd1 << RUN_BITS) - 64'd1;
    localparam int unsigned DUTY_START = 300;
    localparam int unsigned DUTY_STEP  = 10;
    localparam int unsigned DUTY_FULL  = 1024;
    localparam int unsigned RAMP_LEN   = 73;
    localparam int unsigned WEIGHT_DEN = 32855;
    localparam int unsigned PCT_TOP    = 100;

    // Item codes and the register index past the end of the map
    localparam logic       ACT_TICK  = 1'b0;
    localparam logic       ACT_MOVE  = 1'b1;
    localparam logic [2:0] REG_SPARE = 3'd7;

    // Run shape
    localparam int          RAND_PHASES     = 5;
    localparam int          ITEMS_PER_PHASE = 140;
    localparam int          SETTLE_CYCLES   = 200;
    localparam longint      TIMEOUT_NS      = 60_000_000;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        item_t       beat;
        logic [2:0]  reg_idx;
        logic [23:0] reg_data;
        bit          typed;
        result_t     want;
    } plan_row_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_ready;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    result_t     result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = '0;
    logic [23:0] cfg_data     = '0;

    // Expected status beats, oldest first
    result_t     status_due[$];

    // Model state of the motion
    phase_t              drive_phase;
    logic [6:0]          at_percent;
    logic                going_back;
    logic [6:0]          duty_idx;
    logic [7:0]          hold_ticks;
    logic [RUN_BITS-1:0] ms_left;

    // Model copy of the registers
    logic [7:0]  cfg_hold;
    logic [23:0] cfg_ss_len;
    logic [15:0] cfg_full_mm;
    logic [15:0] cfg_step;
    logic [15:0] cfg_weight;
    logic        cfg_wob;

    // Idling controls and bookkeeping
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int stall_left;
    int mismatches     = 0;
    int beats_checked  = 0;
    int item_beats     = 0;
    int moves_started  = 0;
    int moves_short    = 0;
    int moves_refused  = 0;
    int reg_writes     = 0;

    plan_row_t plan[$];

    timed_motor_move_controller #(
        .RUN_TIME_BITS(RUN_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case a handshake never completes
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d results still expected", status_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------
    function automatic plan_row_t item_row(logic act, logic [6:0] tgt);
        plan_row_t r;
        r.kind     = ROW_ITEM;
        r.beat     = '{action: act, target_position: tgt};
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    // Row whose outcome is plain enough to write down directly
    function automatic plan_row_t item_row_exp(logic act, logic [6:0] tgt, logic [10:0] duty,
                                               logic back, logic [6:0] pos, logic busy,
                                               logic acc);
        plan_row_t r;
        r       = item_row(act, tgt);
        r.typed = 1'b1;
        r.want  = '{drive_duty: duty, backward: back, position: pos, busy_res: busy,
                    move_accepted: acc};
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [2:0] idx, logic [23:0] data);
        plan_row_t r;
        r          = item_row(ACT_TICK, 7'd0);
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drive model: advance the motion by one item, return the status beat
    // ------------------------------------------------------------------
    task automatic drive_status_after(input item_t it, output result_t st);
        logic [6:0]  tgt;
        logic [63:0] diff_pct;
        logic [63:0] travel;
        logic [63:0] stp;
        logic [63:0] rt;
        bit          started;
        started = 1'b0;
        if (it.action == ACT_MOVE)
        begin
            if (drive_phase == PH_IDLE)
            begin
                // Targets above full scale saturate; direction follows even a short move
                tgt        = (it.target_position > 7'(PCT_TOP)) ? 7'(PCT_TOP)
                                                                 : it.target_position;
                going_back = (tgt < at_percent);
                diff_pct   = going_back ? 64'(at_percent - tgt) : 64'(tgt - at_percent);
                travel     = diff_pct * 64'(cfg_full_mm / 16'd100) * 64'd256;
                stp        = (cfg_step == '0) ? 64'd1 : 64'(cfg_step);
                if (travel >= 64'(cfg_ss_len) + stp)
                begin
                    if (going_back && cfg_wob)
                        travel = travel + travel * 64'(cfg_weight) / 64'(WEIGHT_DEN);
                    rt = (travel - 64'(cfg_ss_len) + stp - 64'd1) / stp;
                    if (rt > RUN_CAP)
                        rt = RUN_CAP;
                    ms_left    = rt[RUN_BITS-1:0];
                    at_percent = tgt;
                    started    = 1'b1;
                    moves_started++;
                    if (cfg_hold != '0)
                    begin
                        drive_phase = PH_RAMP;
                        duty_idx    = '0;
                        hold_ticks  = '0;
                    end
                    else
                    begin
                        drive_phase = PH_RUN;
                    end
                end
                else
                begin
                    moves_short++;
                end
            end
            else
            begin
                moves_refused++;
            end
        end
        else
        begin
            case (drive_phase)
                PH_RAMP:
                begin
                    hold_ticks = hold_ticks + 8'd1;
                    if (hold_ticks >= cfg_hold)
                    begin
                        hold_ticks = '0;
                        duty_idx   = duty_idx + 7'd1;
                        if (duty_idx >= 7'(RAMP_LEN))
                        begin
                            duty_idx    = '0;
                            drive_phase = PH_RUN;
                        end
                    end
                end
                PH_RUN:
                begin
                    if (ms_left <= 1)
                    begin
                        ms_left     = '0;
                        drive_phase = PH_IDLE;
                    end
                    else
                    begin
                        ms_left = ms_left - 1'b1;
                    end
                end
                default:
                begin
                    drive_phase = PH_IDLE;
                end
            endcase
        end

        case (drive_phase)
            PH_RAMP: st.drive_duty = 11'(DUTY_START + DUTY_STEP * duty_idx);
            PH_RUN:  st.drive_duty = 11'(DUTY_FULL);
            default: st.drive_duty = 11'd0;
        endcase
        st.backward      = going_back;
        st.position      = at_percent;
        st.busy_res      = (drive_phase != PH_IDLE);
        st.move_accepted = started;
    endtask

    // ------------------------------------------------------------------
    // Item channel
    // ------------------------------------------------------------------
    // Offer one beat, hold it until taken, then queue its expected status.
    // Valid stays high on return so back-to-back beats follow without a gap.
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        result_t st;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        drive_status_after(it, st);
        status_due.push_back(typed ? want : st);
        item_beats++;
    endtask

    // Drop valid and wait until every expected status beat has come back
    task automatic wait_results_done();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (status_due.size() != 0);
    endtask

    // Tick until the motion is over; tick targets are random and ignored
    task automatic finish_motion();
        item_t tk;
        while (drive_phase != PH_IDLE)
        begin
            tk.action          = ACT_TICK;
            tk.target_position = 7'($urandom_range(0, 127));
            send_item(tk, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Register channel: write only with the block idle and drained
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
        finish_motion();
        wait_results_done();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SS_STEP:   cfg_hold    = data[7:0];
            REG_SS_LEN:    cfg_ss_len  = data;
            REG_FULL_LEN:  cfg_full_mm = data[15:0];
            REG_STEP:      cfg_step    = data[15:0];
            REG_WEIGHT:    cfg_weight  = data[15:0];
            REG_WOB:       cfg_wob     = data[0];
            // Start position saturates and reloads the position at once
            REG_START_POS: at_percent  = (data[6:0] > 7'(PCT_TOP)) ? 7'(PCT_TOP) : data[6:0];
            default:       ;
        endcase
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result channel: random stall bursts of idle cycles
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(0, 9);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            log_mismatch($sformatf("beat %0d %s: expected %0d, got %0d",
                                   beats_checked, name, want, got));
    endtask

    // Compare every accepted status beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (status_due.size() == 0)
            begin
                log_mismatch($sformatf("status beat with nothing expected: duty %0d pos %0d",
                                       result.drive_duty, result.position));
            end
            else
            begin
                want = status_due.pop_front();
                beats_checked++;
                check_field("drive_duty",    want.drive_duty,    result.drive_duty);
                check_field("backward",      want.backward,      result.backward);
                check_field("position",      want.position,      result.position);
                check_field("busy_res",      want.busy_res,      result.busy_res);
                check_field("move_accepted", want.move_accepted, result.move_accepted);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        item_t       it;
        plan_row_t   row;
        int          sent;
        int unsigned span_mm;
        int unsigned step_val;
        int unsigned ss_len;
        int unsigned hold;
        logic [15:0] full_mm;

        // Register defaults and idle, forward, position zero
        cfg_hold    = 8'd10;
        cfg_ss_len  = '0;
        cfg_full_mm = '0;
        cfg_step    = 16'd256;
        cfg_weight  = '0;
        cfg_wob     = 1'b0;
        drive_phase = PH_IDLE;
        at_percent  = '0;
        going_back  = 1'b0;
        duty_idx    = '0;
        hold_ticks  = '0;
        ms_left     = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state, then zero length: every move is too short
        plan.push_back(item_row_exp(ACT_TICK, 7'd0,   11'd0, 1'b0, 7'd0, 1'b0, 1'b0));
        plan.push_back(item_row_exp(ACT_MOVE, 7'd100, 11'd0, 1'b0, 7'd0, 1'b0, 1'b0));
        // Longest length, fastest step, no ramp: full duty at once, target saturated
        plan.push_back(reg_row(REG_FULL_LEN, 24'h00FFFF));
        plan.push_back(reg_row(REG_STEP,     24'h00FFFF));
        plan.push_back(reg_row(REG_SS_STEP,  24'h000000));
        plan.push_back(item_row_exp(ACT_MOVE, 7'd127, 11'd1024, 1'b0, 7'd100, 1'b1, 1'b1));
        // A move while running is refused and changes nothing
        plan.push_back(item_row_exp(ACT_MOVE, 7'd0,   11'd1024, 1'b0, 7'd100, 1'b1, 1'b0));
        plan.push_back(item_row(ACT_TICK, 7'd127));
        // Heaviest load on a full backward move
        plan.push_back(reg_row(REG_WOB,    24'h000001));
        plan.push_back(reg_row(REG_WEIGHT, 24'h00FFFF));
        plan.push_back(item_row(ACT_MOVE, 7'd0));
        plan.push_back(item_row(ACT_TICK, 7'd0));
        // Start position saturates; soft start longer than any travel
        plan.push_back(reg_row(REG_START_POS, 24'hFFFFFF));
        plan.push_back(reg_row(REG_SS_LEN,    24'hFFFFFF));
        plan.push_back(item_row_exp(ACT_MOVE, 7'd0,   11'd0, 1'b1, 7'd100, 1'b0, 1'b0));
        plan.push_back(item_row_exp(ACT_MOVE, 7'd100, 11'd0, 1'b0, 7'd100, 1'b0, 1'b0));
        plan.push_back(item_row(ACT_MOVE, 7'd127));
        // One percent of a short span with zero step (taken as one), one-tick hold
        plan.push_back(reg_row(REG_SS_LEN,    24'd200));
        plan.push_back(reg_row(REG_FULL_LEN,  24'd199));
        plan.push_back(reg_row(REG_STEP,      24'd0));
        plan.push_back(reg_row(REG_SS_STEP,   24'd1));
        plan.push_back(reg_row(REG_WEIGHT,    24'd0));
        plan.push_back(reg_row(REG_WOB,       24'd0));
        plan.push_back(reg_row(REG_START_POS, 24'd50));
        plan.push_back(reg_row(REG_SPARE,     24'hFFFFFF));
        plan.push_back(item_row_exp(ACT_MOVE, 7'd51, 11'd300, 1'b0, 7'd51, 1'b1, 1'b1));
        plan.push_back(item_row(ACT_TICK, 7'd0));
        plan.push_back(item_row(ACT_TICK, 7'd85));
        plan.push_back(item_row(ACT_TICK, 7'd42));
        plan.push_back(item_row(ACT_MOVE, 7'd0));
        // Longest hold per ramp step on a backward move
        plan.push_back(reg_row(REG_SS_STEP, 24'hFFFFFF));
        plan.push_back(item_row_exp(ACT_MOVE, 7'd49, 11'd300, 1'b1, 7'd49, 1'b1, 1'b1));
        plan.push_back(item_row(ACT_TICK, 7'd0));
        plan.push_back(item_row(ACT_TICK, 7'd0));

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_REG)
                write_reg(row.reg_idx, row.reg_data);
            else
                send_item(row.beat, row.typed, row.want);
        end

        // Random settings; lengths and steps are picked so a full move lasts
        // tens of milliseconds, with an occasional long span up to the maximum
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            full_mm  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(100, 3000));
            span_mm  = full_mm / 100;
            step_val = (span_mm * 25600) / $urandom_range(4, 40);
            if (step_val > 65535)
                step_val = 65535;
            if (step_val == 0)
                step_val = $urandom_range(0, 65535);
            ss_len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, span_mm * 7680);
            hold     = (p == 0) ? 0 : (p == 1) ? 1 : $urandom_range(0, 3);

            // Unused upper data bits carry noise the block must drop
            write_reg(REG_SS_STEP,   {16'($urandom), 8'(hold)});
            write_reg(REG_SS_LEN,    24'(ss_len));
            write_reg(REG_FULL_LEN,  {8'($urandom), full_mm});
            write_reg(REG_STEP,      {8'($urandom), 16'(step_val)});
            write_reg(REG_WEIGHT,    24'($urandom));
            write_reg(REG_WOB,       24'($urandom));
            write_reg(REG_START_POS, {17'($urandom), 7'($urandom_range(0, 127))});
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_SPARE, 24'($urandom));

            // Some settings run without idling; the last one always does
            gaps_on   = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            stalls_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // Hold the sender until the pipeline is empty now and then
                if ((p == 0 && sent == ITEMS_PER_PHASE / 2)
                    || (gaps_on && $urandom_range(0, 99) == 0))
                    wait_results_done();
                // Mostly moves when idle and ticks while in motion
                if (drive_phase == PH_IDLE)
                    it.action = ($urandom_range(0, 1) == 1) ? ACT_MOVE : ACT_TICK;
                else
                    it.action = ($urandom_range(0, 15) == 0) ? ACT_MOVE : ACT_TICK;
                it.target_position = ($urandom_range(0, 9) == 0)
                                     ? 7'($urandom_range(101, 127))
                                     : 7'($urandom_range(0, 100));
                if (!(it.action == ACT_MOVE && drive_phase != PH_IDLE))
                    sent++;
                send_item(it, 1'b0, '0);
            end
        end

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d item beats: %0d moves started, %0d too short, %0d refused.",
                 item_beats, moves_started, moves_short, moves_refused);
        $display("%0d register writes over %0d random settings; %0d status beats compared.",
                 reg_writes, RAND_PHASES, beats_checked);
        if (mismatches == 0 && status_due.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d expected beats never arrived",
                     mismatches, status_due.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
